>>> hdl/jbu_pkg.sv
// shared types and constants for the joint bilateral upsampler
package jbu_pkg;
	localparam int MAX_SCALE     = 16;
	localparam int RANGE_DEPTH   = 768;
	localparam int SAMPLE_BITS   = 16;
	localparam int WEIGHT_BITS   = 16;
	localparam int SPATIAL_DEPTH = 2 * MAX_SCALE + 1;
	localparam int RIDX_BITS     = $clog2(RANGE_DEPTH);
	localparam int SIDX_BITS     = $clog2(SPATIAL_DEPTH);
	localparam int PROD_BITS     = 2 * WEIGHT_BITS;
	localparam int WSUM_BITS     = PROD_BITS + 2;
	localparam int ACC_BITS      = PROD_BITS + SAMPLE_BITS + 2;
	localparam int NUM_BITS      = ACC_BITS + 1;
	localparam int DEN_BITS      = WSUM_BITS + 1;
	localparam int QUO_BITS      = NUM_BITS;

	typedef enum logic [1:0] {
		FN_RANGE   = 2'd0,
		FN_SPATIAL = 2'd1,
		FN_CORNER  = 2'd2,
		FN_PIXEL   = 2'd3
	} func_t;

	localparam logic CFG_SCALE_X = 1'b0;
	localparam logic CFG_SCALE_Y = 1'b1;

	// work descriptor handed from the front end to the back end
	typedef struct packed {
		logic [1:0]             func;
		logic [9:0]             index;
		logic [WEIGHT_BITS-1:0] weight;
		logic [23:0]            color;
		logic [SAMPLE_BITS-1:0] sample;
		logic [SIDX_BITS-1:0]   sidx0;
		logic [SIDX_BITS-1:0]   sidx1;
		logic [SIDX_BITS-1:0]   sidx2;
		logic [SIDX_BITS-1:0]   sidx3;
	} job_t;

	typedef struct packed {
		logic [15:0] pixel_value;
		logic        weight_sum_zero;
	} res_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_FETCH,
		BK_MUL,
		BK_ACC,
		BK_DIV,
		BK_OUT
	} bk_state_t;
endpackage

>>> hdl/jbu_front.sv
// front end: clamps offsets and builds spatial table indices
module jbu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [4:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        func,
	input  logic [9:0]        index,
	input  logic [15:0]       table_weight,
	input  logic [23:0]       guide_color,
	input  logic [15:0]       sample,
	input  logic [3:0]        offset_x,
	input  logic [3:0]        offset_y,
	output logic              job_valid,
	input  logic              job_stall,
	output jbu_pkg::job_t     job
);
	import jbu_pkg::*;

	logic [4:0] scale_x_q, scale_y_q;
	logic [5:0] dw, dh, k, l;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= 5'd2;
			scale_y_q <= 5'd2;
		end else if (cfg_we) begin
			if (cfg_index == CFG_SCALE_X) scale_x_q <= cfg_data;
			else scale_y_q <= cfg_data;
		end
	end

	function automatic logic [5:0] clamp_s(input logic [4:0] s);
		if (s == 5'd0) return 6'd1;
		if ({1'b0, s} > 6'(MAX_SCALE)) return 6'(MAX_SCALE);
		return {1'b0, s};
	endfunction

	always_comb begin
		dw = clamp_s(scale_x_q);
		dh = clamp_s(scale_y_q);
		k = ({2'b0, offset_x} >= dw) ? dw - 6'd1 : {2'b0, offset_x};
		l = ({2'b0, offset_y} >= dh) ? dh - 6'd1 : {2'b0, offset_y};
	end

	assign in_stall = job_valid && job_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) job_valid <= 1'b0;
		else if (!in_stall) job_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			job.func   <= func;
			job.index  <= index;
			job.weight <= table_weight[WEIGHT_BITS-1:0];
			job.color  <= guide_color;
			job.sample <= sample[SAMPLE_BITS-1:0];
			job.sidx0  <= SIDX_BITS'(k + l);
			job.sidx1  <= SIDX_BITS'(dw - k + l);
			job.sidx2  <= SIDX_BITS'(k + dh - l);
			job.sidx3  <= SIDX_BITS'(dw - k + dh - l);
		end
	end
endmodule

>>> hdl/jbu_queue.sv
// two-entry queue between front and back ends
module jbu_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_stall,
	input  jbu_pkg::job_t wr_data,
	output logic          rd_valid,
	input  logic          rd_stall,
	output jbu_pkg::job_t rd_data
);
	import jbu_pkg::*;

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_stall = cnt_q == 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end
endmodule

>>> hdl/jbu_back.sv
// back end: tables, corner store, weighting and division
module jbu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_stall,
	input  jbu_pkg::job_t job,
	output logic          out_valid,
	input  logic          out_stall,
	output jbu_pkg::res_t res
);
	import jbu_pkg::*;

	logic [WEIGHT_BITS-1:0] range_mem [RANGE_DEPTH];
	logic [WEIGHT_BITS-1:0] spat_mem [SPATIAL_DEPTH];
	logic [23:0]            col_q [4];
	logic [SAMPLE_BITS-1:0] smp_q [4];

	bk_state_t state_q, state_d;
	logic [1:0]             cn_q;
	job_t                   cur_q;
	logic [WEIGHT_BITS-1:0] rw_q, sw_q;
	logic                   rok_q, sok_q;
	logic [PROD_BITS-1:0]   w_q;
	logic [WSUM_BITS-1:0]   wsum_q;
	logic [ACC_BITS-1:0]    acc_q;
	logic [NUM_BITS-1:0]    rem_q;
	logic [DEN_BITS-1:0]    den_q;
	logic [QUO_BITS-1:0]    quo_q;
	logic [$clog2(QUO_BITS+1)-1:0] bit_q;
	res_t                   res_q;
	logic                   ov_q;

	logic [9:0]            col_dist;
	logic [SIDX_BITS-1:0]  sidx;
	logic [23:0]           cc;
	logic                  take;
	logic [NUM_BITS+DEN_BITS-1:0] trial;

	function automatic logic [7:0] ad8(input logic [7:0] a, input logic [7:0] b);
		return a > b ? a - b : b - a;
	endfunction

	always_comb begin
		cc = col_q[cn_q];
		col_dist = 10'(ad8(cc[7:0], cur_q.color[7:0]))
			+ 10'(ad8(cc[15:8], cur_q.color[15:8]))
			+ 10'(ad8(cc[23:16], cur_q.color[23:16]));
		unique case (cn_q)
			2'd0: sidx = cur_q.sidx0;
			2'd1: sidx = cur_q.sidx1;
			2'd2: sidx = cur_q.sidx2;
			2'd3: sidx = cur_q.sidx3;
			default: sidx = cur_q.sidx0;
		endcase
	end

	assign job_stall = state_q != BK_IDLE;
	assign take      = job_valid && !job_stall;
	assign out_valid = ov_q;
	assign res       = res_q;
	// divisor lined up with quotient bit bit_q, halved below for bit_q-1
	assign trial     = {{NUM_BITS{1'b0}}, den_q} << bit_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (take && job.func == FN_PIXEL) state_d = BK_FETCH;
			BK_FETCH: state_d = BK_MUL;
			BK_MUL:   state_d = BK_ACC;
			BK_ACC:   if (cn_q == 2'd3) state_d = BK_DIV; else state_d = BK_FETCH;
			BK_DIV:   if (bit_q == '0 || wsum_q == '0) state_d = BK_OUT;
			BK_OUT:   if (!ov_q || !out_stall) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			ov_q    <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				col_q[i] <= '0;
				smp_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == BK_OUT && (!ov_q || !out_stall)) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			if (take && job.func == FN_CORNER && job.index < 10'd4) begin
				col_q[job.index[1:0]] <= job.color;
				smp_q[job.index[1:0]] <= job.sample;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && job.func == FN_RANGE && job.index < 10'(RANGE_DEPTH))
			range_mem[job.index[RIDX_BITS-1:0]] <= job.weight;
		if (take && job.func == FN_SPATIAL && job.index < 10'(SPATIAL_DEPTH))
			spat_mem[job.index[SIDX_BITS-1:0]] <= job.weight;
		rw_q  <= range_mem[col_dist[RIDX_BITS-1:0]];
		sw_q  <= spat_mem[sidx];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				cur_q  <= job;
				cn_q   <= 2'd0;
				wsum_q <= '0;
				acc_q  <= '0;
			end
			BK_FETCH: begin
				rok_q <= 32'(col_dist) < RANGE_DEPTH;
				sok_q <= 32'(sidx) < SPATIAL_DEPTH;
			end
			BK_MUL: w_q <= (rok_q && sok_q) ? PROD_BITS'(sw_q * rw_q) : '0;
			BK_ACC: begin
				wsum_q <= wsum_q + WSUM_BITS'(w_q);
				acc_q  <= acc_q + ACC_BITS'(w_q * smp_q[cn_q]);
				cn_q   <= cn_q + 2'd1;
				if (cn_q == 2'd3) begin
					rem_q <= {acc_q + ACC_BITS'(w_q * smp_q[cn_q]), 1'b0}
						+ NUM_BITS'(wsum_q + WSUM_BITS'(w_q));
					den_q <= {wsum_q + WSUM_BITS'(w_q), 1'b0};
					quo_q <= '0;
					bit_q <= ($clog2(QUO_BITS+1))'(QUO_BITS);
				end
			end
			BK_DIV: begin
				if (bit_q != '0) begin
					bit_q <= bit_q - 1'b1;
					if ({{DEN_BITS{1'b0}}, rem_q} >= (trial >> 1)) begin
						rem_q <= rem_q - NUM_BITS'(trial >> 1);
						quo_q <= quo_q | (QUO_BITS'(1) << (bit_q - 1'b1));
					end
				end
			end
			// result register only moves once the previous item has gone
			BK_OUT: if (!ov_q || !out_stall) begin
				if (wsum_q == '0) begin
					res_q.pixel_value     <= smp_q[0];
					res_q.weight_sum_zero <= 1'b1;
				end else begin
					res_q.pixel_value     <= quo_q[15:0];
					res_q.weight_sum_zero <= 1'b0;
				end
			end
			default: ;
		endcase
	end
endmodule

>>> hdl/joint_bilateral_upsample_pixel.sv
// top level of the joint bilateral upsampler
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | func index table_weight guide_color sample offset_x offset_y
//  out     | out_valid/ out_stall | pixel_value weight_sum_zero
//  cfg     | cfg_we               | cfg_index cfg_data
// table loads and corner loads retire without leaving the back end's idle state
// a pixel takes four rounds of fetch, multiply and accumulate, then a
// restoring divide of one quotient bit a cycle
// reset clears the corner store and sets both scales to 2; the tables stay undefined
// a stalled output holds the back end; the front keeps filling the queue
module joint_bilateral_upsample_pixel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [9:0]  index,
	input  logic [15:0] table_weight,
	input  logic [23:0] guide_color,
	input  logic [15:0] sample,
	input  logic [3:0]  offset_x,
	input  logic [3:0]  offset_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pixel_value,
	output logic        weight_sum_zero
);
	import jbu_pkg::*;

	// front to queue
	logic f_valid, f_stall;
	job_t f_job;
	// queue to back end
	logic q_valid, q_stall;
	job_t q_job;
	res_t r;

	jbu_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .func, .index, .table_weight, .guide_color,
		.sample, .offset_x, .offset_y,
		.job_valid(f_valid), .job_stall(f_stall), .job(f_job)
	);

	jbu_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_job),
		.rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_job)
	);

	jbu_back u_back (
		.clk, .arst_n,
		.job_valid(q_valid), .job_stall(q_stall), .job(q_job),
		.out_valid, .out_stall, .res(r)
	);

	assign pixel_value     = r.pixel_value;
	assign weight_sum_zero = r.weight_sum_zero;
endmodule

>>> bench/testbench.sv
// self-checking bench for the joint bilateral upsampler: table fill, directed cases, random traffic
`timescale 1ns / 1ps

module testbench;
	import jbu_pkg::*;

	localparam int SETTLE_CYCLES = 120;
	localparam int LONG_HOLD     = 400;
	localparam int CYCLE_LIMIT   = 2000000;

	// one item on the input channel
	typedef struct {
		func_t       func;
		logic [9:0]  index;
		logic [15:0] table_weight;
		logic [23:0] guide_color;
		logic [15:0] sample;
		logic [3:0]  offset_x;
		logic [3:0]  offset_y;
	} pixel_req_t;

	typedef struct {
		logic [15:0] pixel_value;
		logic        weight_sum_zero;
	} pixel_res_t;

	// shadow copy of the upsampler state and the pixels it still owes
	class upsample_scoreboard;
		logic [15:0] range_tab [RANGE_DEPTH];
		logic [15:0] spatial_tab [SPATIAL_DEPTH];
		logic [23:0] corner_color [4];
		logic [15:0] corner_sample [4];
		logic [4:0]  scale_x;
		logic [4:0]  scale_y;
		pixel_res_t  owed_pixels [$];
		int          errors;

		function new();
			for (int i = 0; i < 4; i++) begin
				corner_color[i]  = '0;
				corner_sample[i] = '0;
			end
			scale_x = 5'd2;
			scale_y = 5'd2;
			errors  = 0;
		endfunction

		function void set_scale(logic sel, logic [4:0] value);
			if (sel == CFG_SCALE_X) scale_x = value;
			else scale_y = value;
		endfunction

		function int unsigned clamp_scale(logic [4:0] s);
			if (s == 0) return 1;
			if (s > MAX_SCALE) return MAX_SCALE;
			return s;
		endfunction

		function int unsigned color_dist(logic [23:0] a, logic [23:0] b);
			int unsigned d;
			int unsigned x;
			int unsigned y;
			d = 0;
			for (int ch = 0; ch < 3; ch++) begin
				x = a[8*ch +: 8];
				y = b[8*ch +: 8];
				d += (x > y) ? x - y : y - x;
			end
			return d;
		endfunction

		function void note_item(pixel_req_t r);
			int unsigned dw, dh, k, l;
			int unsigned sidx [4];
			longint unsigned w, wsum, acc;
			pixel_res_t res;
			case (r.func)
				FN_RANGE: begin
					if (r.index < RANGE_DEPTH) range_tab[r.index] = r.table_weight;
				end
				FN_SPATIAL: begin
					if (r.index < SPATIAL_DEPTH) spatial_tab[r.index] = r.table_weight;
				end
				FN_CORNER: begin
					if (r.index < 4) begin
						corner_color[r.index]  = r.guide_color;
						corner_sample[r.index] = r.sample;
					end
				end
				default: begin
					dw = clamp_scale(scale_x);
					dh = clamp_scale(scale_y);
					k  = (r.offset_x >= dw) ? dw - 1 : r.offset_x;
					l  = (r.offset_y >= dh) ? dh - 1 : r.offset_y;
					sidx[0] = k + l;
					sidx[1] = dw - k + l;
					sidx[2] = k + dh - l;
					sidx[3] = dw - k + dh - l;
					wsum = 0;
					acc  = 0;
					for (int c = 0; c < 4; c++) begin
						w = longint'(spatial_tab[sidx[c]]) *
							longint'(range_tab[color_dist(corner_color[c], r.guide_color)]);
						wsum += w;
						acc  += w * corner_sample[c];
					end
					if (wsum == 0) begin
						res.pixel_value     = corner_sample[0];
						res.weight_sum_zero = 1'b1;
					end else begin
						res.pixel_value     = 16'((2 * acc + wsum) / (2 * wsum));
						res.weight_sum_zero = 1'b0;
					end
					owed_pixels.push_back(res);
				end
			endcase
		endfunction

		function void check_pixel(logic [15:0] value, logic zero);
			pixel_res_t want;
			if (owed_pixels.size() == 0) begin
				$error("pixel arrived with none owed: pixel_value %0d weight_sum_zero %0d",
					value, zero);
				errors++;
				return;
			end
			want = owed_pixels.pop_front();
			if (value !== want.pixel_value) begin
				$error("pixel_value: expected %0d, got %0d", want.pixel_value, value);
				errors++;
			end
			if (zero !== want.weight_sum_zero) begin
				$error("weight_sum_zero: expected %0d, got %0d", want.weight_sum_zero, zero);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [4:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  func;
	logic [9:0]  index;
	logic [15:0] table_weight;
	logic [23:0] guide_color;
	logic [15:0] sample;
	logic [3:0]  offset_x;
	logic [3:0]  offset_y;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] pixel_value;
	logic        weight_sum_zero;

	upsample_scoreboard sb;
	int  burst_left;
	bit  hold_req;
	int  cycle_count;

	joint_bilateral_upsample_pixel u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.index           (index),
		.table_weight    (table_weight),
		.guide_color     (guide_color),
		.sample          (sample),
		.offset_x        (offset_x),
		.offset_y        (offset_y),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pixel_value     (pixel_value),
		.weight_sum_zero (weight_sum_zero)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop if the block hangs
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// receiver: stall pattern changes mode now and then, plus one long hold-off on request
	initial begin
		int mode;
		int mode_left;
		int held;
		out_stall = 1'b0;
		mode      = 0;
		mode_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				held = 0;
				out_stall = 1'b1;
				while (held < LONG_HOLD) begin
					@(negedge clk);
					held++;
				end
				hold_req = 1'b0;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 300);
			end
			mode_left--;
			case (mode)
				0: out_stall = 1'b0;
				1: out_stall = ($urandom_range(0, 3) == 0);
				default: out_stall = ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	// results are taken at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_pixel(pixel_value, weight_sum_zero);
	end

	// present one item, with the sender's burst and gap pattern in front of it
	task automatic send_item(pixel_req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid     = 1'b1;
		func         = r.func;
		index        = r.index;
		table_weight = r.table_weight;
		guide_color  = r.guide_color;
		sample       = r.sample;
		offset_x     = r.offset_x;
		offset_y     = r.offset_y;
		do @(posedge clk); while (in_stall);
		sb.note_item(r);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// build an item with random content in every field, then the chosen ones fixed
	function automatic pixel_req_t make_item(func_t f, logic [9:0] idx);
		pixel_req_t r;
		r.func         = f;
		r.index        = idx;
		r.table_weight = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
		r.guide_color  = 24'($urandom);
		r.sample       = 16'($urandom);
		r.offset_x     = 4'($urandom);
		r.offset_y     = 4'($urandom);
		return r;
	endfunction

	// wait for the block to drain before touching a register
	task automatic drain();
		while (sb.owed_pixels.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_scales(logic [4:0] sx, logic [4:0] sy);
		drain();
		cfg_we    = 1'b1;
		cfg_index = CFG_SCALE_X;
		cfg_data  = sx;
		@(negedge clk);
		cfg_index = CFG_SCALE_Y;
		cfg_data  = sy;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_scale(CFG_SCALE_X, sx);
		sb.set_scale(CFG_SCALE_Y, sy);
	endtask

	// mostly corner loads followed by pixels, with table rewrites and noise mixed in
	task automatic random_items(int count, bit with_hold, bit with_pause);
		pixel_req_t r;
		int sent;
		int pick;
		bit hold_done;
		bit pause_done;
		sent       = 0;
		hold_done  = 1'b0;
		pause_done = 1'b0;
		while (sent < count) begin
			if (with_hold && !hold_done && sent >= 10) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			if (with_pause && !pause_done && sent >= count / 2) begin
				pause_done = 1'b1;
				in_valid = 1'b0;
				while (sb.owed_pixels.size() != 0) @(negedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				for (int c = 0; c < 4; c++) send_item(make_item(FN_CORNER, 10'(c)));
				sent += 4;
			end else if (pick < 80) begin
				r = make_item(FN_PIXEL, 10'($urandom));
				// now and then reuse a corner colour so the distance is small
				if ($urandom_range(0, 3) == 0)
					r.guide_color = sb.corner_color[$urandom_range(0, 3)];
				send_item(r);
				sent++;
			end else if (pick < 88) begin
				send_item(make_item(FN_RANGE, 10'($urandom)));
				sent++;
			end else if (pick < 94) begin
				send_item(make_item(FN_SPATIAL, 10'($urandom)));
				sent++;
			end else begin
				send_item(make_item(func_t'($urandom_range(0, 3)), 10'($urandom)));
				sent++;
			end
		end
	endtask

	initial begin
		pixel_req_t r;
		logic [4:0] sx_list [10];
		logic [4:0] sy_list [10];
		sb         = new();
		burst_left = 0;
		hold_req   = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_SCALE_X;
		cfg_data     = '0;
		in_valid     = 1'b0;
		func         = FN_RANGE;
		index        = '0;
		table_weight = '0;
		guide_color  = '0;
		sample       = '0;
		offset_x     = '0;
		offset_y     = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// pixel before any corner load, tables filled first so nothing undefined is read
		for (int i = 0; i < RANGE_DEPTH; i++)
			send_item(make_item(FN_RANGE, 10'(i)));
		for (int i = 0; i < SPATIAL_DEPTH; i++)
			send_item(make_item(FN_SPATIAL, 10'(i)));
		send_item(make_item(FN_PIXEL, 10'd0));

		// directed: writes out of range, corner number out of range
		r = make_item(FN_RANGE, 10'd1023);
		r.table_weight = 16'hffff;
		send_item(r);
		send_item(make_item(FN_SPATIAL, 10'(SPATIAL_DEPTH)));
		send_item(make_item(FN_CORNER, 10'd4));
		// full weights and extreme samples and colours
		r = make_item(FN_SPATIAL, 10'd0);
		r.table_weight = 16'hffff;
		send_item(r);
		r = make_item(FN_RANGE, 10'd0);
		r.table_weight = 16'hffff;
		send_item(r);
		for (int c = 0; c < 4; c++) begin
			r = make_item(FN_CORNER, 10'(c));
			r.guide_color = (c[0]) ? 24'hffffff : 24'h000000;
			r.sample      = (c[1]) ? 16'hffff : 16'h0000;
			send_item(r);
		end
		r = make_item(FN_PIXEL, 10'd0);
		r.guide_color = 24'h000000;
		r.offset_x    = 4'd0;
		r.offset_y    = 4'd0;
		send_item(r);
		r.guide_color = 24'hffffff;
		r.offset_x    = 4'd15;
		r.offset_y    = 4'd15;
		send_item(r);
		// zero weight sum: every corner at distance zero with a zero range entry
		r = make_item(FN_RANGE, 10'd0);
		r.table_weight = 16'd0;
		send_item(r);
		for (int c = 0; c < 4; c++) begin
			r = make_item(FN_CORNER, 10'(c));
			r.guide_color = 24'h123456;
			send_item(r);
		end
		r = make_item(FN_PIXEL, 10'd0);
		r.guide_color = 24'h123456;
		send_item(r);
		r = make_item(FN_RANGE, 10'd0);
		r.table_weight = 16'd40000;
		send_item(r);

		// scale settings: defaults, extremes, out of range both ways, then random
		sx_list = '{5'd2, 5'd1, 5'd16, 5'd0, 5'd31, 5'd16, 5'd0, 5'd0, 5'd0, 5'd0};
		sy_list = '{5'd2, 5'd1, 5'd16, 5'd31, 5'd0, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0};
		for (int p = 0; p < 10; p++) begin
			if (p >= 6) begin
				sx_list[p] = 5'($urandom);
				sy_list[p] = 5'($urandom);
			end
			if (p > 0) write_scales(sx_list[p], sy_list[p]);
			random_items(20, p == 1, p == 2);
		end

		in_valid = 1'b0;
		while (sb.owed_pixels.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
